FILE: hdl/lsvm_pkg.sv
package lsvm_pkg;

    // Fixed field widths.
    localparam int FEATURE_BITS  = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_ADDR_BITS = 2;

    // Default sizes of the stores.
    localparam int DEF_MAX_FEATURES = 16;
    localparam int DEF_MAX_SAMPLES  = 256;

    // Register indexes.
    localparam logic [CFG_ADDR_BITS-1:0] REG_LEARN_RATE    = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_REG_STRENGTH  = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_EPOCH_COUNT   = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_FEATURE_COUNT = 2'd3;

    // Register reset values.
    localparam logic [15:0] LEARN_RATE_RESET    = 16'd66;
    localparam logic [15:0] REG_STRENGTH_RESET  = 16'd655;
    localparam logic [15:0] EPOCH_COUNT_RESET   = 16'd1000;
    localparam logic [4:0]  FEATURE_COUNT_RESET = 5'd16;

    // Item modes.
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_TRAIN   = 2'd1;
    localparam logic [1:0] MODE_PREDICT = 2'd2;
    localparam logic [1:0] MODE_CLEAR   = 2'd3;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_ITEM      = 4'd1;
    localparam logic [3:0] OP_PRD_MUL   = 4'd2;
    localparam logic [3:0] OP_PRD_ACC   = 4'd3;
    localparam logic [3:0] OP_PRD_EMIT  = 4'd4;
    localparam logic [3:0] OP_TR_INIT   = 4'd5;
    localparam logic [3:0] OP_SMP_START = 4'd6;
    localparam logic [3:0] OP_RD        = 4'd7;
    localparam logic [3:0] OP_DOT_MUL   = 4'd8;
    localparam logic [3:0] OP_DOT_ACC   = 4'd9;
    localparam logic [3:0] OP_MARGIN    = 4'd10;
    localparam logic [3:0] OP_UPD_MUL   = 4'd11;
    localparam logic [3:0] OP_UPD_WR    = 4'd12;
    localparam logic [3:0] OP_BIAS      = 4'd13;
    localparam logic [3:0] OP_TR_EMIT   = 4'd14;

    typedef struct packed {
        logic [1:0]                     mode;
        logic signed [FEATURE_BITS-1:0] feature_value;
        logic                           label_positive;
    } lsvm_in_t;

    typedef struct packed {
        logic               is_train_done;
        logic               class_positive;
        logic signed [31:0] score;
        logic               saturated;
        logic               store_full;
    } lsvm_out_t;

    // Controller to datapath.
    typedef struct packed {
        logic [3:0] op;
    } lsvm_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
        logic pred_last;
    } lsvm_status_t;

endpackage

FILE: hdl/linear_svm_sgd_train_predict.sv
// Linear SVM with hinge-loss SGD training and streaming prediction.
// Input channel (s_valid/s_ready/s_data): one word per item. Mode load stores
// one Q8.8 training feature with its label; the last feature of a sample
// commits it. Mode predict streams one feature; the last feature of a
// sample yields a result word with class and Q16.16 score. Mode train
// zeroes weights and bias, runs epoch_count passes and then yields one
// acknowledge word. Mode clear empties the training store.
// A predict feature passes through the weight memory read port, the
// multiply register and the accumulate register, and the last feature
// then through the output register. Training runs a serial dot product
// pass and a weight update pass per sample through the same port.
// Results sit in an output register; a new input word is accepted while a
// result waits, and only a word that needs the output register stalls
// when the receiver holds m_ready low.
// Configuration port (cfg_we/cfg_addr/cfg_wdata) writes registers; the
// user must write them only while idle, as the block does not enforce it.
// Reset restores register defaults, zero weights and an empty store.
module linear_svm_sgd_train_predict
    import lsvm_pkg::*;
#(
    parameter int MAX_FEATURES = DEF_MAX_FEATURES,
    parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  lsvm_in_t                 s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output lsvm_out_t                m_data,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int NW = $clog2(MAX_FEATURES + 1);
    localparam int SW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    logic [15:0]  learn_rate_reg, learn_rate_next;
    logic [15:0]  reg_strength_reg, reg_strength_next;
    logic [15:0]  epoch_count_reg, epoch_count_next;
    logic [4:0]   feature_count_reg, feature_count_next;

    lsvm_cmd_t    cmd;
    lsvm_status_t status;
    logic [FW-1:0] k_idx;
    logic [SW-1:0] s_idx;
    logic [NW-1:0] nf;
    logic [CW-1:0] samples;

    // Configuration register writes.
    always_comb begin
        learn_rate_next    = learn_rate_reg;
        reg_strength_next  = reg_strength_reg;
        epoch_count_next   = epoch_count_reg;
        feature_count_next = feature_count_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_LEARN_RATE:    learn_rate_next    = cfg_wdata;
                REG_REG_STRENGTH:  reg_strength_next  = cfg_wdata;
                REG_EPOCH_COUNT:   epoch_count_next   = cfg_wdata;
                REG_FEATURE_COUNT: feature_count_next = cfg_wdata[4:0];
                default:           learn_rate_next    = learn_rate_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            learn_rate_reg    <= LEARN_RATE_RESET;
            reg_strength_reg  <= REG_STRENGTH_RESET;
            epoch_count_reg   <= EPOCH_COUNT_RESET;
            feature_count_reg <= FEATURE_COUNT_RESET;
        end else begin
            learn_rate_reg    <= learn_rate_next;
            reg_strength_reg  <= reg_strength_next;
            epoch_count_reg   <= epoch_count_next;
            feature_count_reg <= feature_count_next;
        end
    end

    lsvm_ctrl #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_SAMPLES  (MAX_SAMPLES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_data.mode),
        .status      (status),
        .nf          (nf),
        .samples     (samples),
        .epoch_count (epoch_count_reg),
        .cmd         (cmd),
        .k_idx       (k_idx),
        .s_idx       (s_idx)
    );

    lsvm_dp #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_SAMPLES  (MAX_SAMPLES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .k_idx         (k_idx),
        .s_idx         (s_idx),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .learn_rate    (learn_rate_reg),
        .reg_strength  (reg_strength_reg),
        .feature_count (feature_count_reg),
        .nf            (nf),
        .samples       (samples)
    );

endmodule

FILE: hdl/lsvm_ram.sv
module lsvm_ram
    import lsvm_pkg::*;
#(
    parameter int WIDTH = FEATURE_BITS,
    parameter int DEPTH = DEF_MAX_SAMPLES,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/lsvm_ctrl.sv
module lsvm_ctrl
    import lsvm_pkg::*;
#(
    parameter int MAX_FEATURES = DEF_MAX_FEATURES,
    parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
    localparam int NW = $clog2(MAX_FEATURES + 1),
    localparam int SW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    localparam int CW = $clog2(MAX_SAMPLES + 1)
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [1:0]   s_mode,
    input  lsvm_status_t status,
    input  logic [NW-1:0] nf,
    input  logic [CW-1:0] samples,
    input  logic [15:0]  epoch_count,
    output lsvm_cmd_t    cmd,
    output logic [FW-1:0] k_idx,
    output logic [SW-1:0] s_idx
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_PRD_MUL = 4'd1;
    localparam logic [3:0] ST_PRD_ACC = 4'd2;
    localparam logic [3:0] ST_PRD_OUT = 4'd3;
    localparam logic [3:0] ST_TR_INIT = 4'd4;
    localparam logic [3:0] ST_SMP     = 4'd5;
    localparam logic [3:0] ST_DOT_RD  = 4'd6;
    localparam logic [3:0] ST_DOT_MUL = 4'd7;
    localparam logic [3:0] ST_DOT_ACC = 4'd8;
    localparam logic [3:0] ST_MARGIN  = 4'd9;
    localparam logic [3:0] ST_UPD_RD  = 4'd10;
    localparam logic [3:0] ST_UPD_MUL = 4'd11;
    localparam logic [3:0] ST_UPD_WR  = 4'd12;
    localparam logic [3:0] ST_BIAS    = 4'd13;
    localparam logic [3:0] ST_TR_OUT  = 4'd14;

    logic [3:0]    state_reg, state_next;
    logic [FW-1:0] k_reg, k_next;
    logic [SW-1:0] s_reg, s_next;
    logic [15:0]   e_reg, e_next;
    logic          last_k, last_s, last_e;

    assign last_k = (32'(k_reg) + 32'd1) == 32'(nf);
    assign last_s = (32'(s_reg) + 32'd1) == 32'(samples);
    assign last_e = (32'(e_reg) + 32'd1) == 32'(epoch_count);

    // Sequencer over items, epochs, samples and features.
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        s_next     = s_reg;
        e_next     = e_reg;
        cmd.op     = OP_NONE;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = OP_ITEM;
                    if (s_mode == MODE_TRAIN) begin
                        state_next = ST_TR_INIT;
                    end else if (s_mode == MODE_PREDICT) begin
                        state_next = ST_PRD_MUL;
                    end
                end
            end
            ST_PRD_MUL: begin
                cmd.op     = OP_PRD_MUL;
                state_next = ST_PRD_ACC;
            end
            ST_PRD_ACC: begin
                cmd.op     = OP_PRD_ACC;
                state_next = status.pred_last ? ST_PRD_OUT : ST_IDLE;
            end
            ST_PRD_OUT: begin
                if (status.out_free) begin
                    cmd.op     = OP_PRD_EMIT;
                    state_next = ST_IDLE;
                end
            end
            ST_TR_INIT: begin
                cmd.op = OP_TR_INIT;
                k_next = '0;
                s_next = '0;
                e_next = '0;
                if (samples == '0 || epoch_count == '0) begin
                    state_next = ST_TR_OUT;
                end else begin
                    state_next = ST_SMP;
                end
            end
            ST_SMP: begin
                cmd.op     = OP_SMP_START;
                k_next     = '0;
                state_next = ST_DOT_RD;
            end
            ST_DOT_RD: begin
                cmd.op     = OP_RD;
                state_next = ST_DOT_MUL;
            end
            ST_DOT_MUL: begin
                cmd.op     = OP_DOT_MUL;
                state_next = ST_DOT_ACC;
            end
            ST_DOT_ACC: begin
                cmd.op = OP_DOT_ACC;
                if (last_k) begin
                    k_next     = '0;
                    state_next = ST_MARGIN;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_DOT_RD;
                end
            end
            ST_MARGIN: begin
                cmd.op     = OP_MARGIN;
                state_next = ST_UPD_RD;
            end
            ST_UPD_RD: begin
                cmd.op     = OP_RD;
                state_next = ST_UPD_MUL;
            end
            ST_UPD_MUL: begin
                cmd.op     = OP_UPD_MUL;
                state_next = ST_UPD_WR;
            end
            ST_UPD_WR: begin
                cmd.op = OP_UPD_WR;
                if (last_k) begin
                    state_next = ST_BIAS;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_UPD_RD;
                end
            end
            ST_BIAS: begin
                cmd.op = OP_BIAS;
                if (last_s) begin
                    s_next = '0;
                    if (last_e) begin
                        state_next = ST_TR_OUT;
                    end else begin
                        e_next     = e_reg + 16'd1;
                        state_next = ST_SMP;
                    end
                end else begin
                    s_next     = s_reg + 1'b1;
                    state_next = ST_SMP;
                end
            end
            ST_TR_OUT: begin
                if (status.out_free) begin
                    cmd.op     = OP_TR_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            s_reg     <= '0;
            e_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            s_reg     <= s_next;
            e_reg     <= e_next;
        end
    end

    assign k_idx = k_reg;
    assign s_idx = s_reg;

    // A result is only written into a free output register.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_PRD_EMIT || cmd.op == OP_TR_EMIT) |-> status.out_free)
        else $error("result issued while output register is occupied");

    // A train word starts the training sequence on the next cycle.
    a_train_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_mode == MODE_TRAIN) |=> (state_reg == ST_TR_INIT))
        else $error("train word did not start training");

    // Feature reads stay inside the active feature count.
    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DOT_RD || state_reg == ST_UPD_RD) |-> (32'(k_reg) < 32'(nf)))
        else $error("feature index beyond active count");

    // Sample reads stay inside the loaded samples.
    a_s_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SMP) |-> (32'(s_reg) < 32'(samples)))
        else $error("sample index beyond loaded samples");

endmodule

FILE: hdl/lsvm_dp.sv
module lsvm_dp
    import lsvm_pkg::*;
#(
    parameter int MAX_FEATURES = DEF_MAX_FEATURES,
    parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
    localparam int NW = $clog2(MAX_FEATURES + 1),
    localparam int SW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    localparam int CW = $clog2(MAX_SAMPLES + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  lsvm_cmd_t     cmd,
    output lsvm_status_t  status,
    input  logic [FW-1:0] k_idx,
    input  logic [SW-1:0] s_idx,
    input  lsvm_in_t      s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lsvm_out_t     m_data,
    input  logic [15:0]   learn_rate,
    input  logic [15:0]   reg_strength,
    input  logic [4:0]    feature_count,
    output logic [NW-1:0] nf,
    output logic [CW-1:0] samples
);

    localparam int SDEPTH = (2 ** SW) * (2 ** FW);
    localparam logic signed [31:0] W_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] W_MIN = 32'sh80000000;
    localparam logic signed [47:0] A_MAX = 48'sh7fffffffffff;
    localparam logic signed [47:0] A_MIN = 48'sh800000000000;
    localparam logic signed [48:0] MARGIN_ONE = 49'sd16777216;

    // State registers.
    logic [FW-1:0]           fpos_reg, fpos_next;
    logic                    kind_reg, kind_next;
    logic [CW-1:0]           samples_reg, samples_next;
    logic signed [47:0]      acc_reg, acc_next;
    logic signed [47:0]      prod_reg, prod_next;
    logic signed [31:0]      bias_reg, bias_next;
    logic [16:0]             f_reg, f_next;
    logic signed [33:0]      decay_reg, decay_next;
    logic signed [25:0]      step_reg, step_next;
    logic                    upd_reg, upd_next;
    logic signed [15:0]      x_reg, x_next;
    logic                    pfirst_reg, pfirst_next;
    logic                    plast_reg, plast_next;
    logic                    sat_reg, sat_next;
    logic                    full_reg, full_next;
    logic [MAX_FEATURES-1:0] wvalid_reg, wvalid_next;
    logic                    wvq_reg, wvq_next;
    logic                    m_valid_reg, m_valid_next;
    lsvm_out_t               m_data_reg, m_data_next;

    // Memory ports.
    logic                    smp_we, smp_re;
    logic [SW+FW-1:0]        smp_waddr, smp_raddr;
    logic [15:0]             smp_q;
    logic                    lab_we, lab_re;
    logic [SW-1:0]           lab_waddr, lab_raddr;
    logic [0:0]              lab_q;
    logic                    w_we, w_re;
    logic [FW-1:0]           w_addr_rd;
    logic [31:0]             w_wdata, w_q;

    // Item decode.
    logic                    new_kind, is_last, room;
    logic [FW-1:0]           start_pos;

    // Arithmetic.
    logic signed [31:0]      w_rd;
    logic signed [15:0]      x_sample, mul_x;
    logic signed [47:0]      mul_prod, acc_base;
    logic signed [48:0]      acc_sum;
    logic                    acc_ovf;
    logic signed [47:0]      acc_sat;
    logic signed [49:0]      decay_full;
    logic signed [32:0]      lr_x;
    logic signed [33:0]      lr_sx;
    logic signed [34:0]      wsum;
    logic                    wsum_ovf;
    logic signed [31:0]      w_new;
    logic signed [32:0]      bsum;
    logic signed [48:0]      acc49, margin;
    logic [31:0]             rate_prod;
    logic signed [39:0]      score_wide;
    logic                    score_ovf;
    logic signed [31:0]      score;
    logic                    label_q;
    logic                    out_free;

    // Active feature count: zero counts as one, large values clip.
    always_comb begin
        if (feature_count == '0) begin
            nf = NW'(1);
        end else if (32'(feature_count) > MAX_FEATURES) begin
            nf = NW'(MAX_FEATURES);
        end else begin
            nf = NW'(feature_count);
        end
    end

    assign samples   = samples_reg;
    assign new_kind  = (s_data.mode == MODE_PREDICT);
    assign start_pos = (fpos_reg != '0 && kind_reg != new_kind) ? '0 : fpos_reg;
    assign is_last   = (32'(start_pos) + 32'd1) >= 32'(nf);
    assign room      = samples_reg < CW'(MAX_SAMPLES);
    assign label_q   = lab_q[0];
    assign out_free  = !m_valid_reg || m_ready;

    // Multiply and accumulate for the dot product.
    assign w_rd     = wvq_reg ? signed'(w_q) : '0;
    assign x_sample = signed'(smp_q);
    assign mul_x    = (cmd.op == OP_PRD_MUL) ? x_reg : x_sample;
    assign mul_prod = w_rd * mul_x;
    assign acc_base = (cmd.op == OP_PRD_ACC && pfirst_reg) ?
                      {{8{bias_reg[31]}}, bias_reg, 8'd0} : acc_reg;
    assign acc_sum  = {acc_base[47], acc_base} + {prod_reg[47], prod_reg};
    assign acc_ovf  = acc_sum[48] != acc_sum[47];
    assign acc_sat  = acc_ovf ? (acc_sum[48] ? A_MIN : A_MAX) : acc_sum[47:0];

    // Margin test against one in Q.24.
    assign acc49  = {acc_reg[47], acc_reg};
    assign margin = label_q ? acc49 : -acc49;

    // Weight decay and gradient step.
    assign decay_full = w_rd * $signed({1'b0, f_reg});
    assign lr_x       = $signed({1'b0, learn_rate}) * x_sample;
    assign lr_sx      = label_q ? {lr_x[32], lr_x} : -{lr_x[32], lr_x};
    assign wsum       = {decay_reg[33], decay_reg} + {{9{step_reg[25]}}, step_reg};
    assign wsum_ovf   = wsum[34:31] != {4{wsum[34]}};
    assign w_new      = wsum_ovf ? (wsum[34] ? W_MIN : W_MAX) : wsum[31:0];
    assign bsum       = {bias_reg[31], bias_reg} +
                        (label_q ? {17'd0, learn_rate} : -{17'd0, learn_rate});
    assign rate_prod  = learn_rate * reg_strength;

    // Score is the accumulator in Q16.16, floored and clipped.
    assign score_wide = acc_reg[47:8];
    assign score_ovf  = score_wide[39:31] != {9{score_wide[39]}};
    assign score      = score_ovf ? (score_wide[39] ? W_MIN : W_MAX) : score_wide[31:0];

    // Memory addressing.
    assign smp_waddr = {samples_reg[SW-1:0], start_pos};
    assign smp_raddr = {s_idx, k_idx};
    assign lab_waddr = samples_reg[SW-1:0];
    assign lab_raddr = s_idx;
    assign w_addr_rd = (cmd.op == OP_ITEM) ? start_pos : k_idx;
    assign w_wdata   = w_new;

    // Operation decode.
    always_comb begin
        fpos_next    = fpos_reg;
        kind_next    = kind_reg;
        samples_next = samples_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        bias_next    = bias_reg;
        f_next       = f_reg;
        decay_next   = decay_reg;
        step_next    = step_reg;
        upd_next     = upd_reg;
        x_next       = x_reg;
        pfirst_next  = pfirst_reg;
        plast_next   = plast_reg;
        sat_next     = sat_reg;
        full_next    = full_reg;
        wvalid_next  = wvalid_reg;
        wvq_next     = wvq_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        smp_we       = 1'b0;
        smp_re       = 1'b0;
        lab_we       = 1'b0;
        lab_re       = 1'b0;
        w_we         = 1'b0;
        w_re         = 1'b0;
        unique case (cmd.op)
            OP_ITEM: begin
                unique case (s_data.mode)
                    MODE_LOAD: begin
                        kind_next = 1'b0;
                        smp_we    = room;
                        if (!room) begin
                            full_next = 1'b1;
                        end
                        if (is_last) begin
                            fpos_next = '0;
                            if (room) begin
                                lab_we       = 1'b1;
                                samples_next = samples_reg + 1'b1;
                            end
                        end else begin
                            fpos_next = start_pos + 1'b1;
                        end
                    end
                    MODE_PREDICT: begin
                        kind_next   = 1'b1;
                        w_re        = 1'b1;
                        x_next      = s_data.feature_value;
                        pfirst_next = (start_pos == '0);
                        plast_next  = is_last;
                        fpos_next   = is_last ? '0 : start_pos + 1'b1;
                    end
                    MODE_TRAIN: begin
                        fpos_next = '0;
                        acc_next  = '0;
                    end
                    MODE_CLEAR: begin
                        samples_next = '0;
                        fpos_next    = '0;
                        acc_next     = '0;
                        full_next    = 1'b0;
                    end
                    default: begin
                        fpos_next = fpos_reg;
                    end
                endcase
            end
            OP_PRD_MUL, OP_DOT_MUL: begin
                prod_next = mul_prod;
            end
            OP_PRD_ACC, OP_DOT_ACC: begin
                acc_next = acc_sat;
                if (acc_ovf) begin
                    sat_next = 1'b1;
                end
            end
            OP_PRD_EMIT: begin
                m_valid_next               = 1'b1;
                m_data_next.is_train_done  = 1'b0;
                m_data_next.class_positive = !score[31];
                m_data_next.score          = score;
                m_data_next.saturated      = sat_reg || score_ovf;
                m_data_next.store_full     = full_reg;
                sat_next                   = 1'b0;
                acc_next                   = '0;
            end
            OP_TR_INIT: begin
                f_next      = 17'h10000 - {1'b0, rate_prod[31:16]};
                wvalid_next = '0;
                bias_next   = '0;
            end
            OP_SMP_START: begin
                acc_next = {{8{bias_reg[31]}}, bias_reg, 8'd0};
                lab_re   = 1'b1;
            end
            OP_RD: begin
                w_re   = 1'b1;
                smp_re = 1'b1;
            end
            OP_MARGIN: begin
                upd_next = margin < MARGIN_ONE;
            end
            OP_UPD_MUL: begin
                decay_next = decay_full[49:16];
                step_next  = upd_reg ? lr_sx[33:8] : '0;
            end
            OP_UPD_WR: begin
                w_we               = 1'b1;
                wvalid_next[k_idx] = 1'b1;
                if (wsum_ovf) begin
                    sat_next = 1'b1;
                end
            end
            OP_BIAS: begin
                if (upd_reg) begin
                    if (bsum[32] != bsum[31]) begin
                        bias_next = bsum[32] ? W_MIN : W_MAX;
                        sat_next  = 1'b1;
                    end else begin
                        bias_next = bsum[31:0];
                    end
                end
            end
            OP_TR_EMIT: begin
                m_valid_next               = 1'b1;
                m_data_next.is_train_done  = 1'b1;
                m_data_next.class_positive = 1'b0;
                m_data_next.score          = '0;
                m_data_next.saturated      = sat_reg;
                m_data_next.store_full     = full_reg;
                sat_next                   = 1'b0;
            end
            default: begin
                m_data_next = m_data_reg;
            end
        endcase
        if (w_re) begin
            wvq_next = wvalid_reg[w_addr_rd];
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fpos_reg    <= '0;
            kind_reg    <= 1'b0;
            samples_reg <= '0;
            bias_reg    <= '0;
            sat_reg     <= 1'b0;
            full_reg    <= 1'b0;
            wvalid_reg  <= '0;
            wvq_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fpos_reg    <= fpos_next;
            kind_reg    <= kind_next;
            samples_reg <= samples_next;
            bias_reg    <= bias_next;
            sat_reg     <= sat_next;
            full_reg    <= full_next;
            wvalid_reg  <= wvalid_next;
            wvq_reg     <= wvq_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        f_reg      <= f_next;
        decay_reg  <= decay_next;
        step_reg   <= step_next;
        upd_reg    <= upd_next;
        x_reg      <= x_next;
        pfirst_reg <= pfirst_next;
        plast_reg  <= plast_next;
        m_data_reg <= m_data_next;
    end

    lsvm_ram #(.WIDTH(FEATURE_BITS), .DEPTH(SDEPTH)) u_sample_ram (
        .aclk    (aclk),
        .wr_en   (smp_we),
        .wr_addr (smp_waddr),
        .wr_data (s_data.feature_value),
        .rd_en   (smp_re),
        .rd_addr (smp_raddr),
        .rd_data (smp_q)
    );

    lsvm_ram #(.WIDTH(1), .DEPTH(2 ** SW)) u_label_ram (
        .aclk    (aclk),
        .wr_en   (lab_we),
        .wr_addr (lab_waddr),
        .wr_data (s_data.label_positive),
        .rd_en   (lab_re),
        .rd_addr (lab_raddr),
        .rd_data (lab_q)
    );

    lsvm_ram #(.WIDTH(32), .DEPTH(2 ** FW)) u_weight_ram (
        .aclk    (aclk),
        .wr_en   (w_we),
        .wr_addr (k_idx),
        .wr_data (w_wdata),
        .rd_en   (w_re),
        .rd_addr (w_addr_rd),
        .rd_data (w_q)
    );

    assign status.out_free  = out_free;
    assign status.pred_last = plast_reg;
    assign m_valid          = m_valid_reg;
    assign m_data           = m_data_reg;

endmodule
